FILE: rtl/glos_pkg.sv
`default_nettype none
package glos_pkg;

	localparam int MAP_WIDTH_DEF  = 256;
	localparam int MAP_HEIGHT_DEF = 256;

	localparam int COORD_W = 8;
	localparam int DELTA_W = COORD_W + 1;
	// |e| stays below 2*255*255
	localparam int ERR_W   = 2 * COORD_W + 2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [DELTA_W-1:0]        count_t;
	typedef logic signed [ERR_W-1:0]   err_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_XP,
		STEP_XM,
		STEP_YP,
		STEP_YM
	} step_t;

endpackage
`default_nettype wire

FILE: rtl/grid_line_of_sight.sv
`default_nettype none
// Line-of-sight engine on a one-bit wall map, one bit per cell in an on-chip memory.
// After reset the block clears the map one cell per clock and holds busy high for
// that pass (MAP_HEIGHT rows of MAP_WIDTH rounded up to a power of two, each axis
// limited to 256, so 65536 cells with the default 256x256 map). A request is taken
// when start is high and busy is low. A write (opcode 0) returns nothing. A query
// (opcode 1) walks from the target cell to the observer cell in unit steps, reading
// the map once per visited cell through the single read port, and keeps busy high
// until it ends. Its answer shows on visible, marked by valid high for a single cycle,
// in the cycle busy falls; the receiver cannot stall it, so capture it then.
module grid_line_of_sight #(
	parameter int MAP_WIDTH  = glos_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = glos_pkg::MAP_HEIGHT_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire                  opcode,
	input  wire glos_pkg::coord_t cell_x,
	input  wire glos_pkg::coord_t cell_y,
	input  wire                  wall_bit,
	input  wire glos_pkg::coord_t observer_x,
	input  wire glos_pkg::coord_t observer_y,
	output logic                 valid,
	output logic                 visible
);
	import glos_pkg::*;

	localparam int W_EFF = (MAP_WIDTH  < 256) ? MAP_WIDTH  : 256;
	localparam int H_EFF = (MAP_HEIGHT < 256) ? MAP_HEIGHT : 256;
	localparam int XW    = $clog2(W_EFF);
	localparam int YW    = $clog2(H_EFF);
	localparam int AW    = XW + YW;
	localparam int DEPTH = H_EFF * (2 ** XW);
	localparam logic [DELTA_W-1:0] W_LIM = DELTA_W'(W_EFF);
	localparam logic [DELTA_W-1:0] H_LIM = DELTA_W'(H_EFF);
	localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);

	logic map_mem [DEPTH];

	state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	coord_t        x_q, y_q, ox_q, oy_q;
	delta_t        dx_q, dy_q;
	count_t        steps_q, n_q;
	err_t          e_q;
	logic          wall_q;
	logic          rd_vld_s1, rd_data_s1, oob_s1;
	logic          valid_q, visible_q;

	logic          accept, is_query, in_oob, cur_oob, cont, hit;
	logic          mem_we, mem_wdata;
	logic [AW-1:0] mem_waddr, rd_addr;
	step_t         step;
	delta_t        dx_in, dy_in, addend_src;
	count_t        adx, ady;
	err_t          addend;
	logic          add_neg;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_query = (opcode == OP_QUERY);
	assign in_oob   = ({1'b0, cell_x} >= W_LIM) || ({1'b0, cell_y} >= H_LIM);
	assign cur_oob  = ({1'b0, x_q} >= W_LIM) || ({1'b0, y_q} >= H_LIM);
	assign rd_addr  = {y_q[YW-1:0], x_q[XW-1:0]};
	assign cont     = (n_q < steps_q) && ((x_q != ox_q) || (y_q != oy_q));
	assign hit      = rd_vld_s1 && (rd_data_s1 || oob_s1);

	assign dx_in = $signed({1'b0, observer_x}) - $signed({1'b0, cell_x});
	assign dy_in = $signed({1'b0, observer_y}) - $signed({1'b0, cell_y});
	assign adx   = dx_in[DELTA_W-1] ? count_t'(-dx_in) : count_t'(dx_in);
	assign ady   = dy_in[DELTA_W-1] ? count_t'(-dy_in) : count_t'(dy_in);

	// pick the unit step from the sign of the error and the quadrant of the delta
	always_comb begin
		step = STEP_NONE;
		if (e_q > 0) begin
			if (dx_q >= 0 && dy_q > 0)
				step = STEP_YP;
			else if (dx_q > 0 && dy_q <= 0)
				step = STEP_XP;
			else if (dx_q < 0 && dy_q >= 0)
				step = STEP_XM;
			else if (dx_q <= 0 && dy_q < 0)
				step = STEP_YM;
		end else begin
			if (dx_q > 0 && dy_q >= 0)
				step = STEP_XP;
			else if (dx_q >= 0 && dy_q < 0)
				step = STEP_YM;
			else if (dx_q <= 0 && dy_q > 0)
				step = STEP_YP;
			else if (dx_q < 0 && dy_q <= 0)
				step = STEP_XM;
		end
	end

	// error update: x moves add or subtract dy, y moves subtract or add dx
	always_comb begin
		case (step)
			STEP_XP: begin
				addend_src = dy_q;
				add_neg    = 1'b0;
			end
			STEP_XM: begin
				addend_src = dy_q;
				add_neg    = 1'b1;
			end
			STEP_YP: begin
				addend_src = dx_q;
				add_neg    = 1'b1;
			end
			STEP_YM: begin
				addend_src = dx_q;
				add_neg    = 1'b0;
			end
			default: begin
				addend_src = '0;
				add_neg    = 1'b0;
			end
		endcase
		addend = ERR_W'(addend_src);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && is_query)
					state_d = ST_WALK;
			end
			ST_WALK: begin
				if (!cont)
					state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 1'b0;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE: begin
				mem_we    = accept && !is_query && !in_oob;
				mem_waddr = {cell_y[YW-1:0], cell_x[XW-1:0]};
				mem_wdata = wall_bit;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= map_mem[rd_addr];
		oob_s1     <= cur_oob;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_WALK);
			valid_q   <= (state_q == ST_FINISH);
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					x_q     <= cell_x;
					y_q     <= cell_y;
					ox_q    <= observer_x;
					oy_q    <= observer_y;
					dx_q    <= dx_in;
					dy_q    <= dy_in;
					steps_q <= adx + ady;
					n_q     <= '0;
					e_q     <= '0;
					wall_q  <= 1'b0;
				end
			end
			ST_WALK: begin
				wall_q <= wall_q || hit;
				if (cont) begin
					n_q <= n_q + 1'b1;
					e_q <= e_q + (add_neg ? ~addend : addend) + ERR_W'(add_neg);
					case (step)
						STEP_XP: x_q <= x_q + 1'b1;
						STEP_XM: x_q <= x_q - 1'b1;
						STEP_YP: y_q <= y_q + 1'b1;
						STEP_YM: y_q <= y_q - 1'b1;
						default: x_q <= x_q;
					endcase
				end
			end
			ST_FINISH: visible_q <= !(wall_q || hit);
			default:   wall_q <= wall_q;
		endcase
	end

	assign busy    = (state_q != ST_IDLE);
	assign valid   = valid_q;
	assign visible = visible_q;

endmodule
`default_nettype wire
